### rtl/core/bpdp_pkg.sv
// Shared types and constants of the bit-plane popcount dot product block.
package bpdp_pkg;

  localparam int WORD_W      = 64;
  localparam int BYTES_W     = WORD_W / 8;
  localparam int PLANE_PORTS = 8;
  localparam int CNT_W       = 7;
  localparam int DIM_W       = 13;
  localparam int QB_W        = 4;
  localparam int NB_W        = DIM_W - 2;
  localparam int NW_W        = DIM_W - 5;
  localparam int SUM_W       = 21;
  localparam int OUT_W       = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);
  localparam logic [QB_W-1:0]  QB_RESET  = QB_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM        = 2'd0,
    CFG_QUERY_BITS = 2'd1
  } bpdp_cfg_e;

  typedef struct packed {
    logic full;
    logic valid;
  } bpdp_qstat_t;

  typedef logic [PLANE_PORTS-1:0][WORD_W-1:0] bpdp_planes_t;

  function automatic logic [CNT_W-1:0] popcount(input logic [WORD_W-1:0] v);
    logic [CNT_W-1:0] lvl [WORD_W];
    for (int i = 0; i < WORD_W; i++) begin
      lvl[i] = CNT_W'(v[i]);
    end
    for (int s = 1; s < WORD_W; s = s * 2) begin
      for (int i = 0; i < WORD_W; i = i + 2 * s) begin
        lvl[i] = lvl[i] + lvl[i+s];
      end
    end
    return lvl[0];
  endfunction

endpackage

### rtl/core/bpdp_front.sv
// Front end: word counting, trailing byte mask and per-plane popcounts.
module bpdp_front #(
  parameter int MAX_DIM = 4096,
  parameter int PLANES  = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [bpdp_pkg::WORD_W-1:0]       code_word_i,
  input  bpdp_pkg::bpdp_planes_t            planes_i,
  input  logic [bpdp_pkg::DIM_W-1:0]        dim_i,
  input  logic [bpdp_pkg::QB_W-1:0]         query_bits_i,
  input  bpdp_pkg::bpdp_qstat_t             qstat_i,
  output logic                              push_o,
  output logic [PLANES*bpdp_pkg::CNT_W:0]   push_data_o
);

  localparam int MAX_WORDS = (MAX_DIM + 63) / 64;
  localparam int WIDX_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CMP_W     = (WIDX_W + 4 > 12) ? WIDX_W + 4 : 12;
  localparam int DW        = bpdp_pkg::DIM_W;

  logic [WIDX_W-1:0]              widx_q, widx_d;
  logic [DW-1:0]                  eff_dim;
  logic [DW:0]                    dim_b, dim_w;
  logic [bpdp_pkg::NB_W-1:0]      nbytes;
  logic [bpdp_pkg::NW_W-1:0]      nwords;
  logic [CMP_W-1:0]               first_byte;
  logic [bpdp_pkg::WORD_W-1:0]    code_m;
  logic                           last;
  logic                           accept;
  logic                           planes_ok;

  always_comb begin
    eff_dim = dim_i;
    if (dim_i == '0) begin
      eff_dim = DW'(1);
    end
    if (32'(dim_i) > MAX_DIM) begin
      eff_dim = DW'(MAX_DIM);
    end
    dim_b  = {1'b0, eff_dim} + (DW+1)'(7);
    dim_w  = {1'b0, eff_dim} + (DW+1)'(63);
    nbytes = dim_b[DW:3];
    nwords = dim_w[DW:6];
  end

  assign first_byte = CMP_W'(widx_q) << 3;
  assign last       = (CMP_W'(widx_q) + CMP_W'(1)) >= CMP_W'(nwords);
  assign accept     = in_valid_i && !qstat_i.full;
  assign planes_ok  = 32'(query_bits_i) <= PLANES;

  always_comb begin
    for (int k = 0; k < bpdp_pkg::BYTES_W; k++) begin
      code_m[k*8 +: 8] = (CMP_W'(nbytes) > first_byte + CMP_W'(k)) ?
                         code_word_i[k*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    push_data_o[PLANES*bpdp_pkg::CNT_W] = last;
    for (int j = 0; j < PLANES; j++) begin
      push_data_o[j*bpdp_pkg::CNT_W +: bpdp_pkg::CNT_W] =
        (planes_ok && (32'(query_bits_i) > j)) ?
        bpdp_pkg::popcount(code_m & planes_i[j]) : '0;
    end
  end

  assign push_o = accept;
  assign widx_d = last ? '0 : widx_q + WIDX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q <= '0;
    end else if (accept) begin
      widx_q <= widx_d;
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> widx_q == '0)
    else $error("word index did not restart after last word");

endmodule

### rtl/core/bpdp_queue.sv
// Two-entry queue between front and back ends.
module bpdp_queue #(
  parameter int WIDTH = 57
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [WIDTH-1:0]      push_data_i,
  input  logic                  pop_i,
  output bpdp_pkg::bpdp_qstat_t qstat_o,
  output logic [WIDTH-1:0]      pop_data_o
);

  logic [WIDTH-1:0]                  mem_q [bpdp_pkg::QUEUE_DEPTH];
  logic [bpdp_pkg::PTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [bpdp_pkg::QCNT_W-1:0]       count_q, count_d;

  assign qstat_o.full  = count_q == bpdp_pkg::QCNT_W'(bpdp_pkg::QUEUE_DEPTH);
  assign qstat_o.valid = count_q != '0;
  assign pop_data_o    = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + bpdp_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - bpdp_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + bpdp_pkg::PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + bpdp_pkg::PTR_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bpdp_pkg::QCNT_W'(bpdp_pkg::QUEUE_DEPTH))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

endmodule

### rtl/core/bpdp_back.sv
// Back end: weighted sum of plane counts, accumulation and result register.
module bpdp_back #(
  parameter int PLANES = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bpdp_pkg::bpdp_qstat_t            qstat_i,
  input  logic [PLANES*bpdp_pkg::CNT_W:0]  q_data_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bpdp_pkg::OUT_W-1:0]       dot_product_o
);

  localparam int ADD_W = bpdp_pkg::CNT_W + PLANES;

  logic [ADD_W-1:0]               add;
  logic [bpdp_pkg::SUM_W-1:0]     sum_q, sum_d, total;
  logic [bpdp_pkg::OUT_W-1:0]     out_q;
  logic                           out_valid_q, out_valid_d;
  logic                           last;
  logic                           out_free;

  assign last     = q_data_i[PLANES*bpdp_pkg::CNT_W];
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = qstat_i.valid && (!last || out_free);

  always_comb begin
    add = '0;
    for (int j = 0; j < PLANES; j++) begin
      add = add + (ADD_W'(q_data_i[j*bpdp_pkg::CNT_W +: bpdp_pkg::CNT_W]) << j);
    end
  end

  assign total = sum_q + bpdp_pkg::SUM_W'(add);

  always_comb begin
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      sum_d = last ? '0 : total;
      if (last) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && last) begin
      out_q <= total[bpdp_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dot_product_o = out_q;

  a_last_sets_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && last |=> out_valid_q && sum_q == '0)
    else $error("last word did not produce a result");

  a_no_pop_over_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && last && out_valid_q |-> !out_stall_i)
    else $error("result overwritten while stalled");

endmodule

### rtl/core/bitplane_popcount_dot_product_top.sv
// Top level of the bit-plane popcount dot product: config registers and wiring.
// Throughput: one word per cycle while in_stall_o is low, one result per vector
// of ceil(dim/64) words. A last word passes the queue register, then the result
// register, to reach dot_product_o; a stalled earlier result keeps it queued.
// Reset clears the word counter, running sum, queue and result valid; dim
// returns to 64 and query_bits to 1. No clearing pass is needed.
module bitplane_popcount_dot_product_top #(
  parameter int MAX_DIM = 4096,
  parameter int PLANES  = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bpdp_pkg::WORD_W-1:0]         code_word_i,
  input  logic [bpdp_pkg::WORD_W-1:0]         plane_0_i,
  input  logic [bpdp_pkg::WORD_W-1:0]         plane_1_i,
  input  logic [bpdp_pkg::WORD_W-1:0]         plane_2_i,
  input  logic [bpdp_pkg::WORD_W-1:0]         plane_3_i,
  input  logic [bpdp_pkg::WORD_W-1:0]         plane_4_i,
  input  logic [bpdp_pkg::WORD_W-1:0]         plane_5_i,
  input  logic [bpdp_pkg::WORD_W-1:0]         plane_6_i,
  input  logic [bpdp_pkg::WORD_W-1:0]         plane_7_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bpdp_pkg::OUT_W-1:0]          dot_product_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bpdp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bpdp_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int QW = PLANES * bpdp_pkg::CNT_W + 1;

  logic [bpdp_pkg::DIM_W-1:0]  dim_q;
  logic [bpdp_pkg::QB_W-1:0]   qbits_q;
  bpdp_pkg::bpdp_planes_t      planes;
  bpdp_pkg::bpdp_qstat_t       qstat;
  logic                        push, pop;
  logic [QW-1:0]               push_data, pop_data;

  assign planes = {plane_7_i, plane_6_i, plane_5_i, plane_4_i,
                   plane_3_i, plane_2_i, plane_1_i, plane_0_i};
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = qstat.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q   <= bpdp_pkg::DIM_RESET;
      qbits_q <= bpdp_pkg::QB_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bpdp_pkg::bpdp_cfg_e'(cfg_index_i))
        bpdp_pkg::CFG_DIM: begin
          dim_q <= cfg_data_i[bpdp_pkg::DIM_W-1:0];
        end
        bpdp_pkg::CFG_QUERY_BITS: begin
          qbits_q <= cfg_data_i[bpdp_pkg::QB_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  bpdp_front #(
    .MAX_DIM (MAX_DIM),
    .PLANES  (PLANES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .code_word_i  (code_word_i),
    .planes_i     (planes),
    .dim_i        (dim_q),
    .query_bits_i (qbits_q),
    .qstat_i      (qstat),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  bpdp_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .qstat_o     (qstat),
    .pop_data_o  (pop_data)
  );

  bpdp_back #(
    .PLANES (PLANES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .qstat_i       (qstat),
    .q_data_i      (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .dot_product_o (dot_product_o)
  );

endmodule
